### hdl/assert_macros.svh
// Assertion helpers; expect clk and arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition holds at every clock edge outside reset.
`define QWT_ASSERT(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// Antecedent implies consequent in the same cycle.
`define QWT_ASSERT_IMP(label, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error(msg);

`endif

### hdl/qwt_pkg.sv
package qwt_pkg;

	localparam int BYTE_W = 8;
	localparam int SCAN_W = 4;

	typedef logic [BYTE_W-1:0] byte_t;
	typedef logic [SCAN_W-1:0] scan_t;

	typedef enum logic [2:0] {
		CLS_OTHER  = 3'd0,
		CLS_BLANK  = 3'd1,
		CLS_BSLASH = 3'd2,
		CLS_DQUOTE = 3'd3,
		CLS_END    = 3'd4,
		CLS_SQUOTE = 3'd5
	} cls_t;

	// scanner states; FINAL_A/FINAL_B are never held
	localparam scan_t ST_START  = 4'd0;
	localparam scan_t ST_DQ     = 4'd1;
	localparam scan_t ST_DQ_ESC = 4'd2;
	localparam scan_t ST_WORD   = 4'd3;
	localparam scan_t ST_ESC    = 4'd4;
	localparam scan_t ST_FINAL_A = 4'd5;
	localparam scan_t ST_SQ     = 4'd6;
	localparam scan_t ST_SQ_ESC = 4'd7;
	localparam scan_t ST_FINAL_B = 4'd8;

	localparam byte_t CH_NUL    = 8'h00;
	localparam byte_t CH_BSLASH = 8'h5c;
	localparam byte_t CH_DQUOTE = 8'h22;
	localparam byte_t CH_SQUOTE = 8'h27;
	localparam byte_t CH_SPACE  = 8'h20;
	localparam byte_t CH_TAB    = 8'h09;

	typedef struct packed {
		scan_t nxt;
		logic  emit;
	} trans_t;

	typedef struct packed {
		scan_t scan;
		logic  nonempty;
		logic  discarding;
	} ctx_t;

	typedef struct packed {
		byte_t ch;
		logic  char_valid;
		logic  word_end;
		logic  line_end;
		logic  cut_short;
	} res_t;

	function automatic trans_t mk(scan_t n, logic e);
		trans_t t;
		t.nxt  = n;
		t.emit = e;
		return t;
	endfunction

	function automatic logic is_final(scan_t s);
		return (s == ST_FINAL_A) || (s == ST_FINAL_B);
	endfunction

	// transition table, rows by state, columns by class
	function automatic trans_t lookup(scan_t st, cls_t cls);
		trans_t t;
		t = mk(ST_START, 1'b0);
		case (st)
			ST_DQ: begin
				case (cls)
					CLS_BSLASH: t = mk(ST_DQ_ESC, 1'b0);
					CLS_DQUOTE: t = mk(ST_WORD, 1'b0);
					CLS_END:    t = mk(ST_FINAL_A, 1'b0);
					default:    t = mk(ST_DQ, 1'b1);
				endcase
			end
			ST_DQ_ESC: begin
				t = (cls == CLS_END) ? mk(ST_FINAL_A, 1'b0) : mk(ST_DQ, 1'b1);
			end
			ST_WORD: begin
				case (cls)
					CLS_OTHER:  t = mk(ST_WORD, 1'b1);
					CLS_BLANK:  t = mk(ST_FINAL_A, 1'b0);
					CLS_BSLASH: t = mk(ST_ESC, 1'b0);
					CLS_DQUOTE: t = mk(ST_DQ, 1'b0);
					CLS_END:    t = mk(ST_FINAL_A, 1'b0);
					CLS_SQUOTE: t = mk(ST_SQ, 1'b0);
					default:    t = mk(ST_WORD, 1'b1);
				endcase
			end
			ST_ESC: begin
				t = (cls == CLS_END) ? mk(ST_FINAL_A, 1'b0) : mk(ST_WORD, 1'b1);
			end
			ST_SQ: begin
				case (cls)
					CLS_BSLASH: t = mk(ST_SQ_ESC, 1'b0);
					CLS_END:    t = mk(ST_FINAL_A, 1'b0);
					CLS_SQUOTE: t = mk(ST_WORD, 1'b0);
					default:    t = mk(ST_SQ, 1'b1);
				endcase
			end
			ST_SQ_ESC: begin
				t = (cls == CLS_END) ? mk(ST_FINAL_A, 1'b0) : mk(ST_SQ, 1'b1);
			end
			default: begin
				// start of word; also final rows and codes off the table
				case (cls)
					CLS_OTHER:  t = mk(ST_WORD, 1'b1);
					CLS_BLANK:  t = mk(ST_START, 1'b0);
					CLS_BSLASH: t = mk(ST_ESC, 1'b0);
					CLS_DQUOTE: t = mk(ST_DQ, 1'b0);
					CLS_END:    t = mk(ST_FINAL_B, 1'b0);
					CLS_SQUOTE: t = mk(ST_SQ, 1'b0);
					default:    t = mk(ST_START, 1'b0);
				endcase
			end
		endcase
		return t;
	endfunction

endpackage

### hdl/quoted_word_tokenizer.sv
// An accepted input byte is held in the input register, its result in the result register.
// Throughput: one byte per cycle while not stalled; the scanner state update is one table lookup.
// in_stall rises only while a byte waits in the input register and the result
// register is held by out_stall.
// Reset (arst_n low, asynchronous): scanner back to start of word, both stages empty.
`include "assert_macros.svh"

module quoted_word_tokenizer
	import qwt_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_stall,
	input  byte_t in_byte,
	output logic  out_valid,
	input  logic  out_stall,
	output byte_t out_char,
	output logic  char_valid,
	output logic  word_end,
	output logic  line_end,
	output logic  cut_short
);

	logic  valid_s1;
	byte_t byte_s1;
	logic  valid_s2;
	res_t  res_s2;
	ctx_t  ctx_q;

	cls_t  cls;
	res_t  res;
	ctx_t  ctx_nxt;
	logic  out_free;

	qwt_class u_class (
		.in_byte (byte_s1),
		.cls     (cls)
	);

	qwt_step u_step (
		.in_byte (byte_s1),
		.cls     (cls),
		.ctx     (ctx_q),
		.res     (res),
		.ctx_nxt (ctx_nxt)
	);

	assign out_free = !valid_s2 || !out_stall;
	assign in_stall = valid_s1 && !out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			ctx_q    <= '0;
		end else begin
			if (!in_stall) begin
				valid_s1 <= in_valid;
			end
			if (out_free) begin
				valid_s2 <= valid_s1;
				if (valid_s1) begin
					ctx_q <= ctx_nxt;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			byte_s1 <= in_byte;
		end
		if (out_free && valid_s1) begin
			res_s2 <= res;
		end
	end

	assign out_valid  = valid_s2;
	assign out_char   = res_s2.ch;
	assign char_valid = res_s2.char_valid;
	assign word_end   = res_s2.word_end;
	assign line_end   = res_s2.line_end;
	assign cut_short  = res_s2.cut_short;

	`QWT_ASSERT(a_scan_held, (ctx_q.scan != ST_FINAL_A) && (ctx_q.scan != ST_FINAL_B) && (ctx_q.scan <= ST_FINAL_B), "scanner holds a final or unknown state")
	`QWT_ASSERT_IMP(a_cut_discards, valid_s2 && res_s2.cut_short, ctx_q.discarding, "cut_short beat without discarding")
	`QWT_ASSERT_IMP(a_line_resets, valid_s2 && res_s2.line_end, ctx_q == '0, "line_end beat left scanner state")
	`QWT_ASSERT_IMP(a_char_alone, valid_s2 && res_s2.char_valid, !res_s2.word_end && !res_s2.line_end && !res_s2.cut_short, "char beat with an end flag")

endmodule

### hdl/qwt_class.sv
module qwt_class
	import qwt_pkg::*;
(
	input  byte_t in_byte,
	output cls_t  cls
);

	always_comb begin
		case (in_byte)
			CH_NUL:          cls = CLS_END;
			CH_BSLASH:       cls = CLS_BSLASH;
			CH_DQUOTE:       cls = CLS_DQUOTE;
			CH_SQUOTE:       cls = CLS_SQUOTE;
			CH_SPACE, CH_TAB: cls = CLS_BLANK;
			default:         cls = CLS_OTHER;
		endcase
	end

endmodule

### hdl/qwt_step.sv
module qwt_step
	import qwt_pkg::*;
(
	input  byte_t in_byte,
	input  cls_t  cls,
	input  ctx_t  ctx,
	output res_t  res,
	output ctx_t  ctx_nxt
);

	trans_t tr;
	logic   nonempty;

	always_comb begin
		tr       = lookup(ctx.scan, cls);
		res      = '0;
		ctx_nxt  = ctx;
		nonempty = ctx.nonempty;
		if (ctx.discarding) begin
			if (cls == CLS_END) begin
				res.line_end = 1'b1;
				ctx_nxt      = '0;
			end
		end else begin
			if (tr.emit) begin
				res.ch         = in_byte;
				res.char_valid = 1'b1;
				nonempty       = 1'b1;
			end
			if (is_final(tr.nxt)) begin
				res.word_end = nonempty;
				if (cls == CLS_END) begin
					res.line_end = 1'b1;
				end else if (!nonempty) begin
					// empty word: drop the rest of the line
					res.cut_short      = 1'b1;
					ctx_nxt.discarding = 1'b1;
				end
				ctx_nxt.scan     = ST_START;
				ctx_nxt.nonempty = 1'b0;
			end else begin
				ctx_nxt.scan     = tr.nxt;
				ctx_nxt.nonempty = nonempty;
			end
		end
	end

endmodule
